@@ rtl/fsjf_pkg.sv @@
// Package for the job-table scheduler: sizes, codes and record types.
// No dependencies.
package fsjf_pkg;
  localparam int unsigned MaxJobsDef = 64;
  localparam int unsigned LenW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned IdW = 6;
  localparam logic [1:0] PolFifo = 2'd0;
  localparam logic [1:0] PolSjf = 2'd1;
  localparam logic [1:0] PolRr = 2'd2;
  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;
  localparam logic CfgPolicy = 1'b0;
  localparam logic CfgSlice = 1'b1;
  localparam logic KindAdd = 1'b0;

  // One table entry: remaining length, first start, last stop, wait sum.
  typedef struct packed {
    logic [LenW-1:0]  rem;
    logic [TimeW-1:0] first;
    logic [TimeW-1:0] last;
    logic [TimeW-1:0] wsum;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);
endpackage

@@ rtl/fsjf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module fsjf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ rtl/fifo_sjf_rr_job_scheduler_top.sv @@
// Top level of the job-table scheduler: handshake, scan sequencer, update.
// Depends on fsjf_pkg and fsjf_ram.
//
// Channel  | Dir | Handshake                 | Payload
// s_axis   | in  | s_axis_tvalid/tready      | tdata: job_length; tuser: kind
// m_axis   | out | m_axis_tvalid/tready      | tdata: see port comment
// cfg      | in  | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// An add result is valid in the cycle after the beat is accepted. A dispatch
// scans the table one entry per cycle through the RAM read port; its result
// is registered after that scan, through SRead and SExec, or SOut if none is open.
// Done marks live in flip-flops cleared by reset; no clearing pass is needed.
// The result sits in an output register; input waits only while a result
// is held or an item is in work.
module fifo_sjf_rr_job_scheduler_top
  import fsjf_pkg::*;
#(
  parameter int unsigned MaxJobs = MaxJobsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // job_length[15:0]
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // job_id[5:0], ran_for[21:6], job_finished[22], response_time[54:23],
  // turnaround_time[86:55], wait_time[118:87], all_done[119], status[121:120]
  output logic [127:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  localparam int unsigned AW = $clog2(MaxJobs);
  localparam int unsigned CW = $clog2(MaxJobs + 1);

  typedef enum logic [4:0] {
    SIdle = 5'b00001, SScan = 5'b00010, SRead = 5'b00100,
    SExec = 5'b01000, SOut  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [1:0]       pol_q;
  logic [LenW-1:0]  slice_q;
  logic [TimeW-1:0] clk_now_q;
  logic [AW-1:0]    tp_q;
  logic [CW-1:0]    cnt_q;
  logic [MaxJobs-1:0] done_q, begun_q;
  logic [CW-1:0]    k_q;      // scan step issued
  logic             rv_q;     // read data valid for an entry
  logic [AW-1:0]    ra_q;     // address of the entry in rdata
  logic             found_q;
  logic [AW-1:0]    best_q;
  logic [LenW-1:0]  bestlen_q;
  logic [121:0]     res_q, res_d;
  logic             ovalid_q;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  entry_t           wdata, rdata;

  fsjf_ram #(.Width(EntryW), .Depth(MaxJobs)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [1:0] pol;
  assign pol = (pol_q == PolSjf || pol_q == PolRr) ? pol_q : PolFifo;
  assign s_axis_tready = (state_q == SIdle) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {6'd0, res_q};

  // Scan address: round robin starts at the turn pointer and wraps at count.
  logic [CW:0] rr_sum;
  logic [AW-1:0] scan_addr;
  always_comb begin
    rr_sum = {1'b0, CW'(tp_q)} + {1'b0, k_q};
    if (pol == PolRr && rr_sum >= {1'b0, cnt_q}) rr_sum = rr_sum - {1'b0, cnt_q};
    scan_addr = (pol == PolRr) ? rr_sum[AW-1:0] : k_q[AW-1:0];
  end

  // Dispatch arithmetic on the chosen entry.
  logic [LenW-1:0]  sl, ran;
  logic [TimeW-1:0] newclk, nwsum, nfirst;
  logic [LenW-1:0]  nrem;
  logic             fin;
  logic [CW-1:0]    ncnt;
  logic             alld;
  logic [MaxJobs-1:0] done_n, cmask;
  always_comb begin
    sl = (slice_q == '0) ? LenW'(1) : slice_q;
    ran = (pol == PolRr && rdata.rem > sl) ? sl : rdata.rem;
    newclk = clk_now_q + TimeW'(ran);
    nrem = rdata.rem - ran;
    fin = (nrem == '0);
    nfirst = begun_q[best_q] ? rdata.first : clk_now_q;
    nwsum = begun_q[best_q] ? rdata.wsum + (clk_now_q - rdata.last) : '0;
    ncnt = cnt_q + CW'(1);
    done_n = done_q;
    if (fin) done_n[best_q] = 1'b1;
    for (int i = 0; i < MaxJobs; i++) cmask[i] = (i < cnt_q);
  end

  logic [TimeW-1:0] tpn;
  always_comb begin
    tpn = TimeW'(best_q) + TimeW'(1);
    if (tpn >= TimeW'(cnt_q)) tpn = '0;
  end

  always_comb begin
    we = 1'b0; waddr = best_q; wdata = '0;
    raddr = scan_addr;
    alld = &(done_n | ~cmask);
    if (state_q == SIdle && s_axis_tvalid && !ovalid_q &&
        s_axis_tuser == KindAdd && cnt_q < CW'(MaxJobs)) begin
      we = 1'b1; waddr = cnt_q[AW-1:0]; wdata.rem = s_axis_tdata;
    end else if (state_q == SExec) begin
      we = 1'b1;
      wdata.rem = nrem; wdata.first = nfirst; wdata.last = newclk;
      wdata.wsum = nwsum;
    end
    if (state_q == SRead) raddr = best_q;
  end

  always_comb begin
    res_d = '0;
    if (state_q == SExec) begin
      res_d[IdW-1:0] = IdW'(best_q);
      res_d[21:6] = ran;
      res_d[22] = fin;
      if (fin) begin
        res_d[54:23] = nfirst;
        res_d[86:55] = newclk;
        res_d[118:87] = nfirst + nwsum;
      end
      res_d[119] = alld;
    end else if (state_q == SOut) begin
      res_d[121:120] = StEmpty;
      res_d[119] = 1'b1;
    end else if (cnt_q < CW'(MaxJobs)) begin
      res_d[IdW-1:0] = IdW'(cnt_q);
    end else begin
      res_d[121:120] = StFull;
      res_d[119] = &(done_q | ~cmask);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (s_axis_tvalid && s_axis_tready && s_axis_tuser != KindAdd)
               state_d = SScan;
      SScan: if (!rv_q && k_q >= cnt_q) state_d = found_q ? SRead : SOut;
             else if (rv_q && k_q >= cnt_q && (found_q || !done_q[ra_q]))
               state_d = SRead;
             else if (rv_q && pol != PolSjf && !done_q[ra_q]) state_d = SRead;
             else if (rv_q && k_q >= cnt_q) state_d = SOut;
      SRead: state_d = SExec;
      SExec: state_d = SIdle;
      SOut:  state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; pol_q <= PolFifo; slice_q <= LenW'(1);
      clk_now_q <= '0; tp_q <= '0; cnt_q <= '0; done_q <= '0; begun_q <= '0;
      k_q <= '0; rv_q <= 1'b0; ra_q <= '0; found_q <= 1'b0; best_q <= '0;
      bestlen_q <= '0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgPolicy) pol_q <= cfg_data_i[1:0];
        else slice_q <= cfg_data_i;
      end
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        SIdle: begin
          k_q <= '0; rv_q <= 1'b0; found_q <= 1'b0;
          if (s_axis_tvalid && s_axis_tready && s_axis_tuser == KindAdd) begin
            ovalid_q <= 1'b1;
            res_q <= res_d;
            if (cnt_q < CW'(MaxJobs)) begin
              done_q[cnt_q[AW-1:0]] <= 1'b0;
              begun_q[cnt_q[AW-1:0]] <= 1'b0;
              cnt_q <= ncnt;
            end
          end
        end
        SScan: begin
          if (k_q < cnt_q) begin
            rv_q <= 1'b1; ra_q <= scan_addr; k_q <= k_q + CW'(1);
          end else rv_q <= 1'b0;
          if (rv_q && !done_q[ra_q]) begin
            if (!found_q || (pol == PolSjf && rdata.rem < bestlen_q)) begin
              if (!(found_q && pol != PolSjf)) begin
                found_q <= 1'b1; best_q <= ra_q; bestlen_q <= rdata.rem;
              end
            end
          end
        end
        SExec: begin
          begun_q[best_q] <= 1'b1;
          done_q <= done_n;
          clk_now_q <= newclk;
          if (pol == PolRr) tp_q <= tpn[AW-1:0];
          ovalid_q <= 1'b1;
          res_q <= res_d;
        end
        SOut: begin
          ovalid_q <= 1'b1;
          res_q <= res_d;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SExec |=> ovalid_q) else $error("dispatch gave no beat");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MaxJobs)) else $error("count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SRead |-> found_q) else $error("read without pick");
endmodule

@@ tb/tb.sv @@
// Testbench for the job-table scheduler: directed and random add and dispatch
// beats under all three policies, checked against an internal predictor.
// Depends on fsjf_pkg and fifo_sjf_rr_job_scheduler_top.
module tb;
  import fsjf_pkg::*;

  localparam int unsigned NJobs = MaxJobsDef;
  localparam longint CycleLimit = 2000000;

  typedef struct packed {
    logic [1:0]  status;
    logic        all_done;
    logic [31:0] wait_time;
    logic [31:0] turnaround_time;
    logic [31:0] response_time;
    logic        job_finished;
    logic [15:0] ran_for;
    logic [5:0]  job_id;
  } sched_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  fifo_sjf_rr_job_scheduler_top dut (.*);

  always #5 clk_i = ~clk_i;

  logic [15:0] rem_len [NJobs];
  logic        done_q [NJobs];
  logic        begun_q [NJobs];
  logic [31:0] first_q [NJobs];
  logic [31:0] stop_q [NJobs];
  logic [31:0] wsum_q [NJobs];
  logic [31:0] now_q;
  int unsigned turn_q;
  int unsigned count_q;
  logic [1:0]  policy_q;
  logic [15:0] slice_q;

  sched_res_t expected_q[$];
  int errors = 0;
  int hold_off = 0;
  logic stall_req = 1'b0;
  logic stall_seen = 1'b0;
  longint cycles = 0;

  task automatic report(string what, logic [127:0] got, logic [127:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic int choose_job();
    int best;
    best = -1;
    if (count_q == 0) return -1;
    if (policy_q == PolRr) begin
      for (int k = 0; k < count_q; k++) begin
        if (!done_q[(turn_q + k) % count_q]) return (turn_q + k) % count_q;
      end
      return -1;
    end
    for (int i = 0; i < count_q; i++) begin
      if (done_q[i]) continue;
      if (best < 0) begin
        best = i;
        if (policy_q != PolSjf) return best;
      end else if (rem_len[i] < rem_len[best]) begin
        best = i;
      end
    end
    return best;
  endfunction

  function automatic sched_res_t predict_schedule(logic kind, logic [15:0] len);
    sched_res_t r;
    int j;
    logic [15:0] ran;
    logic [15:0] slice;
    r = '0;
    if (kind == KindAdd) begin
      if (count_q >= NJobs) begin
        r.status = StFull;
      end else begin
        r.job_id = count_q[5:0];
        rem_len[count_q] = len;
        done_q[count_q] = 1'b0;
        begun_q[count_q] = 1'b0;
        count_q++;
      end
    end else begin
      j = choose_job();
      if (j < 0) begin
        r.status = StEmpty;
      end else begin
        slice = (slice_q == 0) ? 16'd1 : slice_q;
        ran = rem_len[j];
        if (policy_q == PolRr && ran > slice) ran = slice;
        if (!begun_q[j]) begin
          begun_q[j] = 1'b1;
          first_q[j] = now_q;
          wsum_q[j] = '0;
        end else begin
          wsum_q[j] += now_q - stop_q[j];
        end
        now_q += ran;
        rem_len[j] -= ran;
        stop_q[j] = now_q;
        if (rem_len[j] == 0) begin
          done_q[j] = 1'b1;
          r.job_finished = 1'b1;
          r.response_time = first_q[j];
          r.turnaround_time = now_q;
          r.wait_time = first_q[j] + wsum_q[j];
        end
        if (policy_q == PolRr) turn_q = (j + 1) % count_q;
        r.job_id = j[5:0];
        r.ran_for = ran;
      end
    end
    r.all_done = 1'b1;
    for (int i = 0; i < count_q; i++) if (!done_q[i]) r.all_done = 1'b0;
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // The valid line stays high after an accepted beat until the next call or
  // a drain lowers it, so each time step sees one assignment at most.
  task automatic send_item(logic kind, logic [15:0] len);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= len;
    expected_q.push_back(predict_schedule(kind, len));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgPolicy) policy_q = val[1:0];
    else slice_q = val;
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_item(1'b1, 16'h0);
    send_item(KindAdd, 16'hFFFF);
    send_item(KindAdd, 16'h0);
    send_item(KindAdd, 16'h5);
    send_item(KindAdd, 16'h1);
    send_item(1'b1, 16'hFFFF);
    drain();
    write_cfg(CfgPolicy, PolSjf);
    send_item(1'b1, 16'h0);
    send_item(1'b1, 16'h0);
    drain();
    write_cfg(CfgPolicy, PolRr);
    write_cfg(CfgSlice, 16'd0);
    send_item(KindAdd, 16'h3);
    send_item(1'b1, 16'h0);
    send_item(1'b1, 16'h0);
    drain();
    write_cfg(CfgSlice, 16'hFFFF);
    send_item(1'b1, 16'h0);
    send_item(1'b1, 16'h0);
    send_item(1'b1, 16'h0);
    drain();
    write_cfg(CfgPolicy, 2'd3);
    send_item(1'b1, 16'h0);
  endtask

  task automatic test_table_full();
    while (count_q < NJobs) send_item(KindAdd, 16'($urandom_range(1, 40)));
    send_item(KindAdd, 16'hAAAA);
    send_item(KindAdd, 16'h5555);
  endtask

  task automatic test_random(int n);
    logic kind;
    logic [15:0] len;
    int p;
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 149) begin
        drain();
        write_cfg(CfgPolicy, 2'($urandom_range(0, 3)));
        p = $urandom_range(0, 3);
        write_cfg(CfgSlice, p == 0 ? 16'd1 : p == 1 ? 16'hFFFF : 16'($urandom_range(1, 64)));
      end
      if (i == n / 2) stall_req = 1'b1;
      kind = ($urandom_range(0, 99) < 55) ? 1'b1 : 1'b0;
      p = $urandom_range(0, 99);
      len = p < 5 ? 16'h0 : p < 12 ? 16'($urandom) : 16'($urandom_range(1, 100));
      send_item(kind, len);
    end
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_req && !stall_seen) begin
      stall_seen <= 1'b1;
      hold_off <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) < 70) ||
                       ($urandom_range(0, 99) < 40 && cycles % 4000 < 1000);
    end
  end

  always @(posedge clk_i) begin
    sched_res_t got;
    sched_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[121:0];
      if (expected_q.size() == 0) begin
        report("unexpected beat", 128'(got), '0);
      end else begin
        want = expected_q.pop_front();
        if (got.job_id != want.job_id)
          report("job_id", 128'(got.job_id), 128'(want.job_id));
        if (got.ran_for != want.ran_for)
          report("ran_for", 128'(got.ran_for), 128'(want.ran_for));
        if (got.job_finished != want.job_finished)
          report("job_finished", 128'(got.job_finished), 128'(want.job_finished));
        if (got.response_time != want.response_time)
          report("response_time", 128'(got.response_time), 128'(want.response_time));
        if (got.turnaround_time != want.turnaround_time)
          report("turnaround_time", 128'(got.turnaround_time),
                 128'(want.turnaround_time));
        if (got.wait_time != want.wait_time)
          report("wait_time", 128'(got.wait_time), 128'(want.wait_time));
        if (got.all_done != want.all_done)
          report("all_done", 128'(got.all_done), 128'(want.all_done));
        if (got.status != want.status)
          report("status", 128'(got.status), 128'(want.status));
      end
    end
  end

  initial begin
    for (int i = 0; i < NJobs; i++) begin
      done_q[i] = 1'b0;
      begun_q[i] = 1'b0;
    end
    now_q = '0;
    turn_q = 0;
    count_q = 0;
    policy_q = PolFifo;
    slice_q = 16'd1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_random(1400);
    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
